// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the mode finder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Asserts a property on the rising clock edge, ignored while reset is high.
`define SMF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Asserts that a condition implies a property in the next cycle.
`define SMF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== hdl/smf_pkg.sv =====
// Package with the types, constants and a helper function of the mode finder.
package smf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int USED_W = IDX_W + 1;
   localparam int KEY_W = 32;
   localparam int RSP_CNT_W = 16;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [USED_W-1:0] used_type;
   typedef logic [COUNT_WIDTH-1:0] cnt_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] sample_value;
      logic last_in_set;
   } req_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] mode_value;
      logic [RSP_CNT_W-1:0] mode_count;
      logic table_overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      cnt_type cnt;
   } entry_type;

   typedef struct packed {
      logic we;
      idx_type addr;
      entry_type data;
   } tbl_wr_type;

   typedef struct packed {
      logic key_eq;
      logic key_lt;
      logic cnt_gt;
      logic cnt_eq;
   } cmp_type;

   // Clamps a table count to the width of the result count.
   function automatic logic [RSP_CNT_W-1:0] clamp_count(input cnt_type cnt);
      logic [63:0] wide;
      wide = 64'(cnt);
      if (wide > 64'(2 ** RSP_CNT_W - 1)) begin
         return '1;
      end
      return wide[RSP_CNT_W-1:0];
   endfunction

endpackage

// ===== hdl/smf_table.sv =====
// Table memory of distinct keys and their counts, one write and one registered read port.
module smf_table (
   input  logic               clock,
   input  smf_pkg::tbl_wr_type wr,
   input  logic               rd_en,
   input  smf_pkg::idx_type   rd_addr,
   output smf_pkg::entry_type rd_data
);
   import smf_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/smf_cmp.sv =====
// Shared compare unit for key equality, signed key order and count order.
module smf_cmp (
   input  logic signed [smf_pkg::KEY_W-1:0] a_key,
   input  logic signed [smf_pkg::KEY_W-1:0] b_key,
   input  smf_pkg::cnt_type   a_cnt,
   input  smf_pkg::cnt_type   b_cnt,
   output smf_pkg::cmp_type   result
);
   import smf_pkg::*;

   always_comb begin
      result.key_eq = (a_key == b_key);
      result.key_lt = (a_key < b_key);
      result.cnt_gt = (a_cnt > b_cnt);
      result.cnt_eq = (a_cnt == b_cnt);
   end

endmodule

// ===== hdl/statistical_mode_finder.sv =====
// Each transaction on the request channel carries one value of a set and is searched
// against the stored distinct keys one table entry per cycle. A value keeps req_stall
// high until its search ends on a match or at the end of the table, so a new value is
// taken only once the last one is done. The set's last value adds a second walk over
// the table and a hand-off of the result in ST_OUT, held there while the previous
// result still waits. The table holds 256 distinct values: later new values are
// dropped and flagged. A finished result waits in an output register while the next
// set is already being counted.
`include "assert_macros.svh"

module statistical_mode_finder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smf_pkg::rsp_type rsp_data
);
   import smf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_BEST = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   req_type sample_ff, sample_in;
   used_type scan_idx_ff, scan_idx_in;
   used_type used_ff, used_in;
   logic rd_pend_ff, rd_pend_in;
   idx_type rd_idx_ff, rd_idx_in;
   logic ovf_ff, ovf_in;
   logic signed [KEY_W-1:0] best_key_ff, best_key_in;
   cnt_type best_cnt_ff, best_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   tbl_wr_type wr;
   logic rd_en;
   entry_type rd_data;
   cmp_type cmp;
   logic signed [KEY_W-1:0] b_key;
   logic item_done;
   logic scan_end;
   logic out_free;

   smf_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign b_key = (state_ff == ST_SCAN) ? sample_ff.sample_value : best_key_ff;

   smf_cmp u_cmp (
      .a_key  (rd_data.key),
      .b_key  (b_key),
      .a_cnt  (rd_data.cnt),
      .b_cnt  (best_cnt_ff),
      .result (cmp)
   );

   assign scan_end = (scan_idx_ff == used_ff) && !rd_pend_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      sample_in = sample_ff;
      scan_idx_in = scan_idx_ff;
      used_in = used_ff;
      rd_pend_in = 1'b0;
      rd_idx_in = rd_idx_ff;
      ovf_in = ovf_ff;
      best_key_in = best_key_ff;
      best_cnt_in = best_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      wr = '0;
      rd_en = 1'b0;
      item_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_data;
               scan_idx_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_pend_ff && cmp.key_eq) begin
               wr.we = 1'b1;
               wr.addr = rd_idx_ff;
               wr.data.key = sample_ff.sample_value;
               wr.data.cnt = (rd_data.cnt == '1) ? rd_data.cnt : rd_data.cnt + 1'b1;
               item_done = 1'b1;
            end else if (scan_end) begin
               if (used_ff < used_type'(TABLE_DEPTH)) begin
                  wr.we = 1'b1;
                  wr.addr = used_ff[IDX_W-1:0];
                  wr.data.key = sample_ff.sample_value;
                  wr.data.cnt = cnt_type'(1);
                  used_in = used_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               item_done = 1'b1;
            end else if (scan_idx_ff != used_ff) begin
               rd_en = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (item_done) begin
               rd_pend_in = 1'b0;
               if (sample_ff.last_in_set) begin
                  scan_idx_in = '0;
                  best_key_in = '0;
                  best_cnt_in = '0;
                  state_in = ST_BEST;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BEST: begin
            if (rd_pend_ff && (cmp.cnt_gt || (cmp.cnt_eq && cmp.key_lt))) begin
               best_key_in = rd_data.key;
               best_cnt_in = rd_data.cnt;
            end
            if (scan_end) begin
               state_in = ST_OUT;
            end else if (scan_idx_ff != used_ff) begin
               rd_en = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_in.mode_value = best_key_ff;
               rsp_in.mode_count = clamp_count(best_cnt_ff);
               rsp_in.table_overflow = ovf_ff;
               rsp_valid_in = 1'b1;
               used_in = '0;
               ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         ovf_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         ovf_ff <= ovf_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff <= rd_idx_in;
      best_key_ff <= best_key_in;
      best_cnt_ff <= best_cnt_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `SMF_ASSERT(a_used_in_range, used_ff <= used_type'(TABLE_DEPTH), "Table fill count too big.")
   `SMF_ASSERT(a_no_write_in_best, !(wr.we && state_ff == ST_BEST), "Table written in mode walk.")
   `SMF_ASSERT_NEXT(a_load_src, out_free && state_ff != ST_OUT, !rsp_valid_ff, "Stray result.")

endmodule
